// ----- design/imt_pkg.sv -----
// ----------------------------------------------------------------------------
// In-place matrix transpose: shared definitions
// Sizes, operation codes, status codes, register indexes and the request and
// response bundles of the remainder unit.
// ----------------------------------------------------------------------------
package imt_pkg;

  // Store geometry.
  localparam int unsigned MaxElements = 1024;
  localparam int unsigned ElemW       = 64;
  localparam int unsigned IdxW        = $clog2(MaxElements);
  localparam int unsigned CntW        = IdxW + 1;

  // Shape registers and their product.
  localparam int unsigned CfgW  = 11;
  localparam int unsigned SizeW = 2 * CfgW;

  // Remainder unit: rows * index is reduced modulo (size - 1), a few bits a cycle.
  localparam int unsigned ProdW     = CfgW + IdxW;
  localparam int unsigned ModStep   = 4;
  localparam int unsigned ModCycles = (ProdW + ModStep - 1) / ModStep;
  localparam int unsigned DivW      = ModCycles * ModStep;
  localparam int unsigned ModCntW   = $clog2(ModCycles + 1);

  // Configuration port.
  localparam int unsigned ApbAddrW  = 3;
  localparam int unsigned ApbDataW  = 32;
  localparam int unsigned RegIdxBit = 2;

  typedef enum logic [1:0] {
    FUNC_WRITE     = 2'd0,
    FUNC_TRANSPOSE = 2'd1,
    FUNC_READ      = 2'd2
  } func_e;

  localparam logic STATUS_OK  = 1'b0;
  localparam logic STATUS_ERR = 1'b1;

  localparam logic REG_ROW_COUNT    = 1'b0;
  localparam logic REG_COLUMN_COUNT = 1'b1;

  typedef struct packed {
    logic            start;
    logic [DivW-1:0] dividend;
    logic [IdxW-1:0] modulus;
  } mod_req_t;

  typedef struct packed {
    logic            done;
    logic [IdxW-1:0] remainder;
  } mod_rsp_t;

endpackage

// ----- design/imt_ram.sv -----
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port, read data registered on a read enable.
// ----------------------------------------------------------------------------
module imt_ram #(
  parameter int unsigned Width = 64,
  parameter int unsigned Depth = 1024,
  localparam int unsigned AddrW = $clog2(Depth)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  // Write and registered read.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- design/imt_modu.sv -----
// ----------------------------------------------------------------------------
// Remainder unit
// Reduces a dividend modulo a narrow modulus by restoring steps, several bits
// per cycle, and pulses done when the remainder is ready.
// ----------------------------------------------------------------------------
module imt_modu (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  imt_pkg::mod_req_t req_i,
  output imt_pkg::mod_rsp_t rsp_o
);
  import imt_pkg::*;

  logic [DivW-1:0]    div_q, div_d;
  logic [IdxW-1:0]    rem_q, rem_d;
  logic [IdxW-1:0]    mod_q, mod_d;
  logic [ModCntW-1:0] cnt_q, cnt_d;
  logic               busy_q, busy_d;
  logic               done_q, done_d;
  logic [IdxW:0]      acc;
  logic [DivW-1:0]    sh;

  // Shift the dividend in, most significant bit first, subtracting the
  // modulus whenever the partial remainder reaches it.
  always_comb begin
    div_d  = div_q;
    rem_d  = rem_q;
    mod_d  = mod_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    acc    = {1'b0, rem_q};
    sh     = div_q;
    if (req_i.start) begin
      div_d  = req_i.dividend;
      rem_d  = '0;
      mod_d  = req_i.modulus;
      cnt_d  = ModCntW'(ModCycles);
      busy_d = 1'b1;
    end else if (busy_q) begin
      for (int s = 0; s < ModStep; s++) begin
        acc = {acc[IdxW-1:0], sh[DivW-1]};
        sh  = {sh[DivW-2:0], 1'b0};
        if (acc >= {1'b0, mod_q}) begin
          acc = acc - {1'b0, mod_q};
        end
      end
      div_d = sh;
      rem_d = acc[IdxW-1:0];
      cnt_d = cnt_q - ModCntW'(1);
      if (cnt_q == ModCntW'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  // Control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      busy_q <= busy_d;
      done_q <= done_d;
    end
  end

  // Datapath.
  always_ff @(posedge clk_i) begin
    div_q <= div_d;
    rem_q <= rem_d;
    mod_q <= mod_d;
  end

  assign rsp_o.done      = done_q;
  assign rsp_o.remainder = rem_q;

endmodule

// ----- design/inplace_matrix_transpose.sv -----
// ----------------------------------------------------------------------------
// In-place matrix transpose store
// Holds a row-major matrix of 64-bit words and transposes it in place by
// following permutation cycles through the store.
// ----------------------------------------------------------------------------
// Usage:
//   Input beats carry func, flat_index and element_value; a beat is taken when
//   in_valid_i is high and in_stall_o is low. Every beat yields exactly one
//   result beat (read_value, status, shape_swapped), taken when out_valid_o is
//   high and out_stall_i is low.
//   A write finishes in the decode state; a read waits for the registered read
//   of the store RAM.
//   Transpose of N = rows * cols words clears the visited map, scans each index
//   and moves each word to the destination (rows * k) mod (N - 1) that the
//   remainder unit computes.
//   One item is in work at a time; a new beat is taken once the block is idle,
//   even while the previous result still waits in the output register. A
//   stalled receiver holds the result and, once the next item is done, holds
//   the block too.
//   row_count and column_count sit on the APB port at 0x0 and 0x4; reset sets
//   both to 1 and clears the shape flag. The store is undefined until written.
// ----------------------------------------------------------------------------
module inplace_matrix_transpose (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // Configuration port
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [imt_pkg::ApbAddrW-1:0]  paddr,
  input  logic [imt_pkg::ApbDataW-1:0]  pwdata,
  output logic [imt_pkg::ApbDataW-1:0]  prdata,
  output logic                          pready,
  // Input channel
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic [1:0]                    func_i,
  input  logic [imt_pkg::IdxW-1:0]      flat_index_i,
  input  logic [imt_pkg::ElemW-1:0]     element_value_i,
  // Output channel
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [imt_pkg::ElemW-1:0]     read_value_o,
  output logic                          status_o,
  output logic                          shape_swapped_o
);
  import imt_pkg::*;

  typedef enum logic [10:0] {
    ST_IDLE     = 11'b000_0000_0001,
    ST_EXEC     = 11'b000_0000_0010,
    ST_RDW      = 11'b000_0000_0100,
    ST_CLR      = 11'b000_0000_1000,
    ST_SCAN_RD  = 11'b000_0001_0000,
    ST_SCAN_CHK = 11'b000_0010_0000,
    ST_MUL      = 11'b000_0100_0000,
    ST_MODS     = 11'b000_1000_0000,
    ST_MODW     = 11'b001_0000_0000,
    ST_WALK_RD  = 11'b010_0000_0000,
    ST_WALK_WR  = 11'b100_0000_0000
  } state_e;

  state_e state_q, state_d;

  // Configuration and shape state.
  logic [CfgW-1:0] row_count_q, column_count_q;
  logic            swapped_q, swapped_d;

  // Item held while in work.
  func_e           func_q;
  logic [IdxW-1:0] idx_q;
  logic [ElemW-1:0] val_q;

  // Transpose walk state.
  logic [CntW-1:0]  size_q, size_d;
  logic [CfgW-1:0]  rows_cur_q, rows_cur_d;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic [IdxW-1:0]  pos_q, pos_d;
  logic [IdxW-1:0]  nxt_q, nxt_d;
  logic [ElemW-1:0] carry_q, carry_d;
  logic [DivW-1:0]  prod_q, prod_d;

  // Result staging and output register.
  logic [ElemW-1:0] res_value_q, res_value_d;
  logic             res_status_q, res_status_d;
  logic             out_valid_q, out_valid_d;
  logic [ElemW-1:0] read_value_q;
  logic             status_q;
  logic             shape_q;
  logic             out_load;
  logic             done_item;
  logic             deliver;
  logic             pend_q, pend_d;

  // Memory ports.
  logic             store_we, store_re;
  logic [IdxW-1:0]  store_waddr, store_raddr;
  logic [ElemW-1:0] store_wdata, store_rdata;
  logic             vis_we, vis_re;
  logic [IdxW-1:0]  vis_waddr, vis_raddr;
  logic             vis_wdata, vis_rdata;

  // Remainder unit.
  mod_req_t mod_req;
  mod_rsp_t mod_rsp;

  // Shape arithmetic.
  logic [SizeW-1:0] size_full;
  logic             size_ok;
  logic             idx_ok;
  logic [CntW-1:0]  size_m1;
  logic [ProdW-1:0] mul_full;
  logic             in_accept;
  logic             cfg_we;
  logic             cfg_idx;

  // The input waits while an item is in work or its result is still staged.
  assign in_stall_o = (state_q != ST_IDLE) || pend_q;
  assign in_accept  = in_valid_i && !in_stall_o;

  // Configuration port: registers decoded by the word address bit.
  assign pready  = 1'b1;
  assign cfg_we  = psel && penable && pwrite;
  assign cfg_idx = paddr[RegIdxBit];

  always_comb begin
    unique case (cfg_idx)
      REG_ROW_COUNT:    prdata = ApbDataW'(row_count_q);
      REG_COLUMN_COUNT: prdata = ApbDataW'(column_count_q);
      default:          prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_count_q    <= CfgW'(1);
      column_count_q <= CfgW'(1);
    end else if (cfg_we) begin
      if (cfg_idx == REG_ROW_COUNT) begin
        row_count_q <= pwdata[CfgW-1:0];
      end else begin
        column_count_q <= pwdata[CfgW-1:0];
      end
    end
  end

  // Size check and index range check under the current shape.
  assign size_full = row_count_q * column_count_q;
  assign size_ok   = (row_count_q != '0) && (column_count_q != '0) &&
                     (size_full <= SizeW'(MaxElements));
  assign idx_ok    = (SizeW'(idx_q) < size_full);
  assign size_m1   = size_q - CntW'(1);
  assign mul_full  = rows_cur_q * pos_q;

  // Remainder request: destination of pos is (rows * pos) mod (size - 1).
  assign mod_req.start    = (state_q == ST_MODS);
  assign mod_req.dividend = prod_q;
  assign mod_req.modulus  = size_m1[IdxW-1:0];

  // Output register is free when empty or being emptied this cycle.
  assign out_load = !out_valid_q || !out_stall_i;

  // Sequencer.
  always_comb begin
    state_d      = state_q;
    swapped_d    = swapped_q;
    size_d       = size_q;
    rows_cur_d   = rows_cur_q;
    cnt_d        = cnt_q;
    pos_d        = pos_q;
    nxt_d        = nxt_q;
    carry_d      = carry_q;
    prod_d       = prod_q;
    res_value_d  = res_value_q;
    res_status_d = res_status_q;
    out_valid_d  = out_valid_q && out_stall_i;
    store_we     = 1'b0;
    store_waddr  = idx_q;
    store_wdata  = val_q;
    store_re     = 1'b0;
    store_raddr  = idx_q;
    vis_we       = 1'b0;
    vis_waddr    = cnt_q[IdxW-1:0];
    vis_wdata    = 1'b0;
    vis_re       = 1'b0;
    vis_raddr    = cnt_q[IdxW-1:0];

    unique case (state_q)
      ST_IDLE: begin
        if (in_accept) begin
          state_d = ST_EXEC;
        end
      end

      // Decode the item and decide its path.
      ST_EXEC: begin
        res_value_d  = '0;
        res_status_d = STATUS_ERR;
        state_d      = ST_IDLE;
        unique case (func_q)
          FUNC_WRITE: begin
            if (size_ok && idx_ok) begin
              store_we     = 1'b1;
              res_status_d = STATUS_OK;
            end
          end
          FUNC_READ: begin
            if (size_ok && idx_ok) begin
              store_re = 1'b1;
              state_d  = ST_RDW;
            end
          end
          FUNC_TRANSPOSE: begin
            if (size_ok) begin
              size_d     = size_full[CntW-1:0];
              rows_cur_d = swapped_q ? column_count_q : row_count_q;
              cnt_d      = '0;
              state_d    = ST_CLR;
            end
          end
          default: begin
            state_d = ST_IDLE;
          end
        endcase
      end

      ST_RDW: begin
        res_value_d  = store_rdata;
        res_status_d = STATUS_OK;
        state_d      = ST_IDLE;
      end

      // Clear the visited map over the matrix, one entry a cycle.
      ST_CLR: begin
        vis_we = 1'b1;
        if (cnt_q == size_m1) begin
          cnt_d   = '0;
          state_d = ST_SCAN_RD;
        end else begin
          cnt_d = cnt_q + CntW'(1);
        end
      end

      // Look at the next start index, or finish when all are done.
      ST_SCAN_RD: begin
        if (cnt_q == size_q) begin
          swapped_d    = ~swapped_q;
          res_value_d  = '0;
          res_status_d = STATUS_OK;
          state_d      = ST_IDLE;
        end else begin
          vis_re      = 1'b1;
          store_re    = 1'b1;
          store_raddr = cnt_q[IdxW-1:0];
          state_d     = ST_SCAN_CHK;
        end
      end

      ST_SCAN_CHK: begin
        if (vis_rdata) begin
          cnt_d   = cnt_q + CntW'(1);
          state_d = ST_SCAN_RD;
        end else begin
          carry_d = store_rdata;
          pos_d   = cnt_q[IdxW-1:0];
          state_d = ST_MUL;
        end
      end

      // The last index maps to itself; others go through the remainder unit.
      ST_MUL: begin
        if (CntW'(pos_q) == size_m1) begin
          nxt_d   = pos_q;
          state_d = ST_WALK_RD;
        end else begin
          prod_d  = DivW'(mul_full);
          state_d = ST_MODS;
        end
      end

      ST_MODS: begin
        state_d = ST_MODW;
      end

      ST_MODW: begin
        if (mod_rsp.done) begin
          nxt_d   = mod_rsp.remainder;
          state_d = ST_WALK_RD;
        end
      end

      ST_WALK_RD: begin
        store_re    = 1'b1;
        store_raddr = nxt_q;
        state_d     = ST_WALK_WR;
      end

      // Drop the carried word at its destination and pick up the old one.
      ST_WALK_WR: begin
        store_we    = 1'b1;
        store_waddr = nxt_q;
        store_wdata = carry_q;
        vis_we      = 1'b1;
        vis_waddr   = pos_q;
        vis_wdata   = 1'b1;
        carry_d     = store_rdata;
        pos_d       = nxt_q;
        if (nxt_q == cnt_q[IdxW-1:0]) begin
          cnt_d   = cnt_q + CntW'(1);
          state_d = ST_SCAN_RD;
        end else begin
          state_d = ST_MUL;
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // A finished item waits in the sequencer until the output register frees.
  assign done_item = (state_q != ST_IDLE) && (state_d == ST_IDLE);
  assign deliver   = pend_q && out_load;

  always_comb begin
    pend_d = pend_q;
    if (deliver) begin
      pend_d = 1'b0;
    end
    if (done_item) begin
      pend_d = 1'b1;
    end
  end

  // Control state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      swapped_q   <= 1'b0;
      out_valid_q <= 1'b0;
      pend_q      <= 1'b0;
      cnt_q       <= '0;
    end else begin
      state_q     <= state_d;
      swapped_q   <= swapped_d;
      out_valid_q <= out_valid_d || deliver;
      pend_q      <= pend_d;
      cnt_q       <= cnt_d;
    end
  end

  // Datapath registers.
  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      func_q <= func_e'(func_i);
      idx_q  <= flat_index_i;
      val_q  <= element_value_i;
    end
    size_q       <= size_d;
    rows_cur_q   <= rows_cur_d;
    pos_q        <= pos_d;
    nxt_q        <= nxt_d;
    carry_q      <= carry_d;
    prod_q       <= prod_d;
    res_value_q  <= res_value_d;
    res_status_q <= res_status_d;
    if (deliver) begin
      read_value_q <= res_value_q;
      status_q     <= res_status_q;
      shape_q      <= swapped_q;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign read_value_o    = read_value_q;
  assign status_o        = status_q;
  assign shape_swapped_o = shape_q;

  // Element store.
  imt_ram #(
    .Width(ElemW),
    .Depth(MaxElements)
  ) u_store (
    .clk_i  (clk_i),
    .we_i   (store_we),
    .waddr_i(store_waddr),
    .wdata_i(store_wdata),
    .re_i   (store_re),
    .raddr_i(store_raddr),
    .rdata_o(store_rdata)
  );

  // Visited map.
  imt_ram #(
    .Width(1),
    .Depth(MaxElements)
  ) u_visited (
    .clk_i  (clk_i),
    .we_i   (vis_we),
    .waddr_i(vis_waddr),
    .wdata_i(vis_wdata),
    .re_i   (vis_re),
    .raddr_i(vis_raddr),
    .rdata_o(vis_rdata)
  );

  // Destination index unit.
  imt_modu u_modu (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .req_i (mod_req),
    .rsp_o (mod_rsp)
  );

endmodule

// ----- design/imt_chk.sv -----
// ----------------------------------------------------------------------------
// In-place matrix transpose: port checker
// Watches the channels of the top level and flags results that break the
// one-result-per-beat contract or the output hold rules.
// ----------------------------------------------------------------------------
module imt_chk (
  input logic                      clk_i,
  input logic                      rst_ni,
  input logic                      in_valid_i,
  input logic                      in_stall_o,
  input logic                      out_valid_o,
  input logic                      out_stall_i,
  input logic [imt_pkg::ElemW-1:0] read_value_o,
  input logic                      status_o,
  input logic                      shape_swapped_o
);
  import imt_pkg::*;

  logic [1:0] outst_q, outst_d;
  logic       in_take, out_take;

  assign in_take  = in_valid_i && !in_stall_o;
  assign out_take = out_valid_o && !out_stall_i;

  // Beats taken in minus results taken out.
  always_comb begin
    outst_d = outst_q;
    if (in_take && !out_take) begin
      outst_d = outst_q + 2'd1;
    end else if (!in_take && out_take) begin
      outst_d = outst_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      outst_q <= '0;
    end else begin
      outst_q <= outst_d;
    end
  end

  // No result is offered during reset.
  assert property (@(posedge clk_i) !rst_ni |-> !out_valid_o)
    else $error("result offered during reset");

  // A result is only offered for a beat that was taken.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (outst_q != 2'd0))
    else $error("result without a pending beat");

  // At most one item in work and one result waiting.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    outst_q != 2'd3)
    else $error("too many beats outstanding");

  // A failed request reports a zero word.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (status_o == STATUS_ERR)) |-> (read_value_o == '0))
    else $error("error result with nonzero word");

  // A stalled result holds.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=>
      (out_valid_o && $stable(read_value_o) && $stable(status_o) &&
       $stable(shape_swapped_o)))
    else $error("stalled result changed");

endmodule

bind inplace_matrix_transpose imt_chk u_imt_chk (.*);

// ----- sim/inplace_matrix_transpose_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// In-place matrix transpose store: self-checking testbench
// Drives write, read and transpose beats plus APB shape writes into the store
// and keeps its own copy of the matrix, the shape registers and the shape
// flag. Each result beat is checked field by field against the oldest
// predicted result. Directed corner cases come first. They are followed by
// random traffic under several idle and stall mixes, the largest shapes, and
// a long receiver hold-off.
// ----------------------------------------------------------------------------
module inplace_matrix_transpose_tb;
  import imt_pkg::*;

  localparam int unsigned CycleLimit = 2_000_000;
  localparam logic [1:0]  FuncUnused = 2'd3;

  typedef struct packed {
    logic [ElemW-1:0] read_value;
    logic             status;
    logic             shape_swapped;
  } mat_rsp_t;

  // Clock, reset and block inputs, all known from time zero.
  logic                clk_i           = 1'b0;
  logic                rst_ni          = 1'b0;
  logic                psel            = 1'b0;
  logic                penable         = 1'b0;
  logic                pwrite          = 1'b0;
  logic [ApbAddrW-1:0] paddr           = '0;
  logic [ApbDataW-1:0] pwdata          = '0;
  logic [ApbDataW-1:0] prdata;
  logic                pready;
  logic                in_valid_i      = 1'b0;
  logic                in_stall_o;
  logic [1:0]          func_i          = '0;
  logic [IdxW-1:0]     flat_index_i    = '0;
  logic [ElemW-1:0]    element_value_i = '0;
  logic                out_valid_o;
  logic                out_stall_i     = 1'b0;
  logic [ElemW-1:0]    read_value_o;
  logic                status_o;
  logic                shape_swapped_o;

  // Shadow of the block: matrix words, which entries hold a written word,
  // the shape flag and the two shape registers.
  logic [ElemW-1:0] store_shadow [MaxElements];
  bit               written_shadow [MaxElements];
  bit               swapped_shadow;
  logic [CfgW-1:0]  rows_shadow = CfgW'(1);
  logic [CfgW-1:0]  cols_shadow = CfgW'(1);

  mat_rsp_t    pending_rsp_q [$];
  mat_rsp_t    head_rsp;
  int unsigned fail_count;
  int unsigned cycle_count;
  int unsigned src_idle_pct;
  int unsigned sink_stall_pct;
  int unsigned hold_off_left;

  inplace_matrix_transpose dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .func_i         (func_i),
    .flat_index_i   (flat_index_i),
    .element_value_i(element_value_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .read_value_o   (read_value_o),
    .status_o       (status_o),
    .shape_swapped_o(shape_swapped_o)
  );

  initial begin
    forever #10 clk_i = ~clk_i;
  end

  // Run-length guard.
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CycleLimit) begin
      $display("Verification failed");
      $finish;
    end
  end

  // Receiver: a counted hold-off takes priority over random stalls.
  always @(posedge clk_i) begin
    if (hold_off_left != 0) begin
      out_stall_i <= 1'b1;
      hold_off_left--;
    end else begin
      out_stall_i <= ($urandom_range(99) < sink_stall_pct);
    end
  end

  // Result checker: every accepted result beat is matched with the oldest
  // predicted result.
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o === 1'b1 && !out_stall_i) begin
      if (pending_rsp_q.size() == 0) begin
        $error("result beat with no predicted result waiting");
        fail_count++;
      end else begin
        head_rsp = pending_rsp_q.pop_front();
        if (read_value_o !== head_rsp.read_value) begin
          $error("read_value: expected %h, actual %h", head_rsp.read_value, read_value_o);
          fail_count++;
        end
        if (status_o !== head_rsp.status) begin
          $error("status: expected %0d, actual %0d", head_rsp.status, status_o);
          fail_count++;
        end
        if (shape_swapped_o !== head_rsp.shape_swapped) begin
          $error("shape_swapped: expected %0d, actual %0d", head_rsp.shape_swapped,
                 shape_swapped_o);
          fail_count++;
        end
      end
    end
  end

  // Moves the shadow matrix through the permutation cycles of a transpose of
  // a rows x (size / rows) matrix. Written marks travel with their words.
  function automatic void transpose_shadow(int unsigned rows, int unsigned size);
    bit               moved [MaxElements];
    int unsigned      pos;
    int unsigned      nxt;
    logic [ElemW-1:0] carry;
    logic [ElemW-1:0] held;
    bit               carry_w;
    bit               held_w;
    for (int unsigned i = 0; i < size; i++) begin
      if (!moved[i]) begin
        pos     = i;
        carry   = store_shadow[i];
        carry_w = written_shadow[i];
        do begin
          // The last index is a fixed point; all others go to rows*k mod (size-1).
          if (pos == size - 1) begin
            nxt = pos;
          end else begin
            nxt = (rows * pos) % (size - 1);
          end
          held                = store_shadow[nxt];
          held_w              = written_shadow[nxt];
          store_shadow[nxt]   = carry;
          written_shadow[nxt] = carry_w;
          carry               = held;
          carry_w             = held_w;
          moved[pos]          = 1'b1;
          pos                 = nxt;
        end while (pos != i);
      end
    end
  endfunction

  // Applies one accepted beat to the shadow and returns the result it causes.
  function automatic mat_rsp_t predict_matrix_op(logic [1:0] op, logic [IdxW-1:0] idx,
                                                 logic [ElemW-1:0] word);
    mat_rsp_t    rsp;
    int unsigned size;
    int unsigned rows_now;
    bit          size_ok;
    size     = int'(rows_shadow) * int'(cols_shadow);
    size_ok  = rows_shadow != 0 && cols_shadow != 0 && size <= MaxElements;
    rows_now = swapped_shadow ? int'(cols_shadow) : int'(rows_shadow);
    rsp.read_value = '0;
    rsp.status     = STATUS_ERR;
    case (op)
      FUNC_WRITE: begin
        if (size_ok && idx < size) begin
          store_shadow[idx]   = word;
          written_shadow[idx] = 1'b1;
          rsp.status          = STATUS_OK;
        end
      end
      FUNC_TRANSPOSE: begin
        if (size_ok) begin
          transpose_shadow(rows_now, size);
          swapped_shadow = !swapped_shadow;
          rsp.status     = STATUS_OK;
        end
      end
      FUNC_READ: begin
        if (size_ok && idx < size) begin
          rsp.read_value = store_shadow[idx];
          rsp.status     = STATUS_OK;
        end
      end
      default: ;
    endcase
    rsp.shape_swapped = swapped_shadow;
    return rsp;
  endfunction

  // Random in-range index that holds a written word, or -1 if there is none.
  function automatic int pick_written_index(int unsigned size);
    int hits [$];
    for (int unsigned i = 0; i < size && i < MaxElements; i++) begin
      if (written_shadow[i]) begin
        hits.push_back(int'(i));
      end
    end
    if (hits.size() == 0) begin
      return -1;
    end
    return hits[$urandom_range(hits.size() - 1)];
  endfunction

  function automatic logic [ElemW-1:0] random_word();
    return {$urandom, $urandom};
  endfunction

  // Offers one beat, with an optional random idle gap first, and records the
  // predicted result once the block takes it.
  task automatic send_beat(logic [1:0] op, int unsigned idx, logic [ElemW-1:0] word);
    if (src_idle_pct != 0 && $urandom_range(99) < src_idle_pct) begin
      in_valid_i <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < src_idle_pct);
    end
    in_valid_i      <= 1'b1;
    func_i          <= op;
    flat_index_i    <= IdxW'(idx);
    element_value_i <= word;
    do @(posedge clk_i); while (in_stall_o !== 1'b0);
    pending_rsp_q.push_back(predict_matrix_op(op, IdxW'(idx), word));
  endtask

  // Stops offering beats and waits until every predicted result has arrived.
  task automatic wait_drain();
    in_valid_i <= 1'b0;
    while (pending_rsp_q.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  // APB write: setup cycle, then access cycle until pready.
  task automatic cfg_write(logic reg_idx, int unsigned value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= ApbAddrW'(reg_idx) << RegIdxBit;
    pwdata  <= ApbDataW'(value);
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (pready !== 1'b1);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    if (reg_idx == REG_ROW_COUNT) begin
      rows_shadow = CfgW'(value);
    end else begin
      cols_shadow = CfgW'(value);
    end
  endtask

  task automatic set_shape(int unsigned rows, int unsigned cols);
    wait_drain();
    cfg_write(REG_ROW_COUNT, rows);
    cfg_write(REG_COLUMN_COUNT, cols);
  endtask

  // One shape setting followed by a random mix of operations on it.
  task automatic run_round(int unsigned n_ops);
    int unsigned rows;
    int unsigned cols;
    int unsigned size;
    int unsigned span;
    int unsigned sel;
    int          hit;
    bit          fits;
    sel = $urandom_range(99);
    if (sel < 60) begin
      rows = $urandom_range(1, 6);
      cols = $urandom_range(1, 6);
    end else if (sel < 70) begin
      rows = 1;
      cols = $urandom_range(2, 24);
    end else if (sel < 80) begin
      rows = $urandom_range(2, 24);
      cols = 1;
    end else if (sel < 92) begin
      rows = $urandom_range(4, 9);
      cols = $urandom_range(4, 9);
    end else if (sel < 96) begin
      // A zero register makes the size bad.
      rows = $urandom_range(1) ? 0 : $urandom_range(1, 2047);
      cols = (rows == 0) ? $urandom_range(2047) : 0;
    end else begin
      rows = $urandom_range(33, 2047);
      cols = $urandom_range(32, 2047);
    end
    set_shape(rows, cols);
    size = rows * cols;
    fits = rows != 0 && cols != 0 && size <= MaxElements;
    span = fits ? size : MaxElements;
    repeat (n_ops) begin
      sel = $urandom_range(99);
      if (sel < 35) begin
        send_beat(FUNC_WRITE, $urandom_range(span - 1), random_word());
      end else if (sel < 65) begin
        hit = fits ? pick_written_index(size) : int'($urandom_range(MaxElements - 1));
        if (hit >= 0) begin
          send_beat(FUNC_READ, hit, random_word());
        end else begin
          send_beat(FUNC_WRITE, $urandom_range(span - 1), random_word());
        end
      end else if (sel < 77) begin
        send_beat(FUNC_TRANSPOSE, $urandom_range(MaxElements - 1), random_word());
      end else if (sel < 85 && fits && size < MaxElements) begin
        // Index beyond the matrix.
        send_beat($urandom_range(1) ? FUNC_READ : FUNC_WRITE,
                  $urandom_range(size, MaxElements - 1), random_word());
      end else if (sel < 90) begin
        send_beat(FuncUnused, $urandom_range(MaxElements - 1), random_word());
      end else begin
        send_beat(FUNC_WRITE, $urandom_range(MaxElements - 1), random_word());
      end
    end
  endtask

  // Corner cases: single element, a small non-square matrix, bad sizes.
  task automatic test_directed_cases();
    logic [ElemW-1:0] ones;
    ones           = '1;
    src_idle_pct   = 0;
    sink_stall_pct = 0;
    // Reset shape is 1 x 1; transposing it only flips the shape flag.
    send_beat(FUNC_WRITE, 0, ones);
    send_beat(FUNC_READ, 0, '0);
    send_beat(FUNC_WRITE, 1, random_word());
    send_beat(FUNC_READ, MaxElements - 1, '0);
    send_beat(FUNC_TRANSPOSE, 0, '0);
    send_beat(FUNC_READ, 0, '0);
    send_beat(FuncUnused, MaxElements - 1, ones);
    send_beat(FUNC_TRANSPOSE, MaxElements - 1, ones);
    // Full 2 x 3 matrix, transposed, then read back as 3 x 2.
    set_shape(2, 3);
    send_beat(FUNC_WRITE, 0, '0);
    send_beat(FUNC_WRITE, 1, ones);
    send_beat(FUNC_WRITE, 2, 64'h5555_5555_5555_5555);
    send_beat(FUNC_WRITE, 3, 64'hAAAA_AAAA_AAAA_AAAA);
    send_beat(FUNC_WRITE, 4, random_word());
    send_beat(FUNC_WRITE, 5, random_word());
    send_beat(FUNC_TRANSPOSE, 0, '0);
    send_beat(FUNC_READ, 1, '0);
    send_beat(FUNC_READ, 2, '0);
    send_beat(FUNC_READ, 4, '0);
    // A zero row count refuses everything.
    wait_drain();
    cfg_write(REG_ROW_COUNT, 0);
    send_beat(FUNC_WRITE, 0, ones);
    send_beat(FUNC_TRANSPOSE, 0, '0);
    send_beat(FUNC_READ, 0, '0);
    // A product just above the store, then the largest register values.
    set_shape(33, 32);
    send_beat(FUNC_TRANSPOSE, 0, '0);
    send_beat(FUNC_WRITE, 0, ones);
    set_shape(2047, 2047);
    send_beat(FUNC_READ, 0, '0);
    wait_drain();
  endtask

  task automatic test_random_traffic(int unsigned src_pct, int unsigned sink_pct,
                                     int unsigned n_ops);
    int unsigned done_ops;
    int unsigned chunk;
    src_idle_pct   = src_pct;
    sink_stall_pct = sink_pct;
    done_ops       = 0;
    while (done_ops < n_ops) begin
      chunk = $urandom_range(8, 20);
      if (chunk > n_ops - done_ops) begin
        chunk = n_ops - done_ops;
      end
      run_round(chunk);
      done_ops += chunk;
    end
    wait_drain();
  endtask

  // Largest shapes: a 1024 x 1 and a 1 x 1024 matrix and two other full-store matrices.
  task automatic test_large_shapes();
    int unsigned rows_tab [4] = '{1024, 1, 32, 16};
    int unsigned cols_tab [4] = '{1, 1024, 32, 64};
    int unsigned size;
    int          hit;
    src_idle_pct   = 31;
    sink_stall_pct = 31;
    for (int s = 0; s < 4; s++) begin
      set_shape(rows_tab[s], cols_tab[s]);
      size = rows_tab[s] * cols_tab[s];
      send_beat(FUNC_WRITE, 0, random_word());
      send_beat(FUNC_WRITE, size - 1, random_word());
      send_beat(FUNC_WRITE, $urandom_range(size - 1), random_word());
      send_beat(FUNC_WRITE, $urandom_range(size - 1), random_word());
      send_beat(FUNC_TRANSPOSE, 0, '0);
      repeat (4) begin
        hit = pick_written_index(size);
        send_beat(FUNC_READ, hit, '0);
      end
      send_beat(FUNC_TRANSPOSE, 0, '0);
      repeat (3) begin
        hit = pick_written_index(size);
        send_beat(FUNC_READ, hit, '0);
      end
    end
    wait_drain();
  endtask

  // The receiver holds off long enough for the block to fill and stall its
  // input; afterward the sender pauses until everything has drained.
  task automatic test_backpressure();
    int hit;
    src_idle_pct   = 0;
    sink_stall_pct = 0;
    set_shape(3, 3);
    hold_off_left = 400;
    repeat (16) begin
      if ($urandom_range(1)) begin
        send_beat(FUNC_WRITE, $urandom_range(8), random_word());
      end else begin
        hit = pick_written_index(9);
        if (hit >= 0) begin
          send_beat(FUNC_READ, hit, '0);
        end else begin
          send_beat(FUNC_WRITE, $urandom_range(8), random_word());
        end
      end
    end
    wait_drain();
    send_beat(FUNC_TRANSPOSE, 0, '0);
    repeat (5) begin
      hit = pick_written_index(9);
      send_beat(FUNC_READ, hit, '0);
    end
    wait_drain();
  endtask

  initial begin
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed_cases();
    test_random_traffic(0, 0, 48);
    test_random_traffic(73, 0, 48);
    test_random_traffic(0, 73, 48);
    test_random_traffic(31, 31, 48);
    test_large_shapes();
    test_backpressure();
    wait_drain();
    repeat (40) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
